/* rtl/core/assert_macros.svh */
// Assertion macros shared by the aggregator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_DEF(lbl, prop, msg)
`endif
`endif

/* rtl/core/obla_pkg.sv */
// Types and constants of the order book level aggregator.
package obla_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam int unsigned PRICE_W   = 20;
  localparam int unsigned QTY_IN_W  = 16;
  localparam int unsigned QTY_W     = 32;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned LEVEL_N   = 1 << LEVEL_W;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic                mode;
    logic                side;
    logic [PRICE_W-1:0]  price;
    logic [QTY_IN_W-1:0] quantity;
    logic [LEVEL_W-1:0]  level;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] level_price;
    logic [QTY_W-1:0]   level_quantity;
    logic               level_valid;
  } out_item_t;

  typedef struct packed {
    logic               used;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
  } entry_t;

  typedef struct packed {
    logic hit;
    logic merged;
  } link_t;

endpackage

/* rtl/core/order_book_level_aggregator_core.sv */
// Order book level aggregator top level: two books and the result register.
//
// Input channel in_valid_i / in_stall_o / in_item_i carries one item: an add
// (mode 0) merges a quantity into the level of the same price in the buy or
// sell book, or inserts a new level in sorted order (a full book drops its
// worst level); a read (mode 1) returns one level counted from the best.
// Output channel out_valid_o / out_stall_i / out_item_o carries one result per
// read and none per add. A result shows in the cycle after its read is accepted.
// Each book is a chain of DEPTH level cells that all compare the incoming
// price in the same cycle and shift, merge or insert in place, so one item is
// taken every cycle while in_stall_o is low.
// While a result waits on a stalled receiver, in_stall_o is high and no new
// item is taken; the result holds until taken.
// Reset empties both books at once and drops any pending result.
`include "assert_macros.svh"
module order_book_level_aggregator_core #(
  parameter int unsigned DEPTH = obla_pkg::DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  obla_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output obla_pkg::out_item_t out_item_o
);

  logic                in_acc, add_buy, add_sell, rd_acc;
  obla_pkg::entry_t    buy_rd, sell_rd, sel_rd;
  logic                out_valid_q, out_valid_d;
  obla_pkg::out_item_t out_item_q, out_item_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign add_buy    = in_acc && (in_item_i.mode == obla_pkg::MODE_ADD)
                      && (in_item_i.side == obla_pkg::SIDE_BUY);
  assign add_sell   = in_acc && (in_item_i.mode == obla_pkg::MODE_ADD)
                      && (in_item_i.side == obla_pkg::SIDE_SELL);
  assign rd_acc     = in_acc && (in_item_i.mode == obla_pkg::MODE_READ);

  obla_book #(
    .DEPTH   (DEPTH),
    .IS_SELL (1'b0)
  ) u_buy (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .add_i      (add_buy),
    .price_i    (in_item_i.price),
    .qty_i      (in_item_i.quantity),
    .level_i    (in_item_i.level),
    .rd_entry_o (buy_rd)
  );

  obla_book #(
    .DEPTH   (DEPTH),
    .IS_SELL (1'b1)
  ) u_sell (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .add_i      (add_sell),
    .price_i    (in_item_i.price),
    .qty_i      (in_item_i.quantity),
    .level_i    (in_item_i.level),
    .rd_entry_o (sell_rd)
  );

  always_comb begin
    sel_rd      = (in_item_i.side == obla_pkg::SIDE_SELL) ? sell_rd : buy_rd;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (rd_acc) begin
      out_valid_d = 1'b1;
      out_item_d  = '{level_price:    sel_rd.price,
                      level_quantity: sel_rd.qty,
                      level_valid:    sel_rd.used};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_DEF(a_read_gives_result, rd_acc |=> out_valid_o, "read produced no result")
  `ASSERT_DEF(a_add_no_result, in_acc && !rd_acc && !out_valid_o |=> !out_valid_o,
              "add produced a result")
  `ASSERT_DEF(a_empty_zero, out_valid_o && !out_item_o.level_valid |->
              out_item_o.level_price == '0 && out_item_o.level_quantity == '0,
              "empty level not zero")

endmodule

/* rtl/core/obla_cell.sv */
// One price level cell: compare, merge, insert or take the neighbor's level.
module obla_cell #(
  parameter bit IS_SELL = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          add_i,
  input  logic [obla_pkg::PRICE_W-1:0]  price_i,
  input  logic [obla_pkg::QTY_IN_W-1:0] qty_i,
  input  obla_pkg::link_t               link_i,
  input  obla_pkg::entry_t              prev_entry_i,
  output obla_pkg::link_t               link_o,
  output obla_pkg::entry_t              entry_o
);

  logic                         used_q, used_d;
  logic [obla_pkg::PRICE_W-1:0] price_q, price_d;
  logic [obla_pkg::QTY_W-1:0]   qty_q, qty_d;
  logic                         match, better, hit, first, merge, shift;
  logic [obla_pkg::QTY_W:0]     sum;

  always_comb begin
    match  = used_q && (price_i == price_q);
    better = IS_SELL ? (price_i < price_q) : (price_i > price_q);
    hit    = !used_q || match || better;
    first  = hit && !link_i.hit;
    merge  = first && match;
    shift  = link_i.hit && !link_i.merged;
    sum    = {1'b0, qty_q} + (obla_pkg::QTY_W + 1)'(qty_i);

    used_d  = used_q;
    price_d = price_q;
    qty_d   = qty_q;
    if (add_i) begin
      if (shift) begin
        used_d  = prev_entry_i.used;
        price_d = prev_entry_i.price;
        qty_d   = prev_entry_i.qty;
      end else if (merge) begin
        qty_d = sum[obla_pkg::QTY_W] ? {obla_pkg::QTY_W{1'b1}} : sum[obla_pkg::QTY_W-1:0];
      end else if (first) begin
        used_d  = 1'b1;
        price_d = price_i;
        qty_d   = obla_pkg::QTY_W'(qty_i);
      end
    end
  end

  assign link_o.hit    = hit;
  assign link_o.merged = link_i.merged || merge;
  assign entry_o       = '{used: used_q, price: price_q, qty: qty_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q <= price_d;
    qty_q   <= qty_d;
  end

endmodule

/* rtl/core/obla_book.sv */
// One sorted book: a chain of level cells and the level read select.
`include "assert_macros.svh"
module obla_book #(
  parameter int unsigned DEPTH   = obla_pkg::DEPTH_DEF,
  parameter bit          IS_SELL = 1'b0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          add_i,
  input  logic [obla_pkg::PRICE_W-1:0]  price_i,
  input  logic [obla_pkg::QTY_IN_W-1:0] qty_i,
  input  logic [obla_pkg::LEVEL_W-1:0]  level_i,
  output obla_pkg::entry_t              rd_entry_o
);

  localparam int unsigned RD_N = (DEPTH < obla_pkg::LEVEL_N) ? DEPTH : obla_pkg::LEVEL_N;

  obla_pkg::link_t  link  [DEPTH+1];
  obla_pkg::entry_t entry [DEPTH];
  logic [DEPTH-1:0] used_vec;

  assign link[0] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    obla_pkg::entry_t prev_entry;
    if (k == 0) begin : g_head
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_entry = entry[k-1];
    end
    obla_cell #(
      .IS_SELL (IS_SELL)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .add_i        (add_i),
      .price_i      (price_i),
      .qty_i        (qty_i),
      .link_i       (link[k]),
      .prev_entry_i (prev_entry),
      .link_o       (link[k+1]),
      .entry_o      (entry[k])
    );
    assign used_vec[k] = entry[k].used;
  end

  always_comb begin
    rd_entry_o = '0;
    for (int k = 0; k < RD_N; k++) begin
      if (level_i == obla_pkg::LEVEL_W'(k) && entry[k].used) begin
        rd_entry_o = entry[k];
      end
    end
  end

  `ASSERT_DEF(a_used_prefix, (used_vec & (used_vec + DEPTH'(1))) == '0,
              "used levels not a prefix")
  `ASSERT_DEF(a_add_fills, add_i && !used_vec[0] |=> used_vec[0], "add to empty book lost")
  `ASSERT_DEF(a_rd_empty_zero, !rd_entry_o.used |-> rd_entry_o == '0, "empty read not zero")

endmodule

/* bench/obla_level_checker.sv */
// Checker for the order book level aggregator: watches both channels, predicts reads, compares.
module obla_level_checker
  import obla_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        fail_count_o,
  output int        pending_o
);

  logic [PRICE_W-1:0] lvl_price [2][DEPTH];
  logic [QTY_W-1:0]   lvl_qty   [2][DEPTH];
  logic               lvl_used  [2][DEPTH];
  out_item_t          level_reads_q [$];
  out_item_t          want;
  int                 mismatches = 0;
  int                 pending_cnt = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = pending_cnt;

  function automatic void apply_order(input logic side, input logic [PRICE_W-1:0] px,
                                      input logic [QTY_IN_W-1:0] qty);
    bit             placed;
    logic [QTY_W:0] sum;
    placed = 1'b0;
    for (int i = 0; i < DEPTH && !placed; i++) begin
      if (!lvl_used[side][i]) begin
        lvl_price[side][i] = px;
        lvl_qty[side][i]   = QTY_W'(qty);
        lvl_used[side][i]  = 1'b1;
        placed = 1'b1;
      end else if (lvl_price[side][i] == px) begin
        sum = {1'b0, lvl_qty[side][i]} + (QTY_W + 1)'(qty);
        lvl_qty[side][i] = sum[QTY_W] ? '1 : sum[QTY_W-1:0];
        placed = 1'b1;
      end else if ((side == SIDE_SELL) ? (px < lvl_price[side][i])
                                       : (px > lvl_price[side][i])) begin
        // shift worse levels down, last one drops off
        for (int j = DEPTH - 1; j > i; j--) begin
          lvl_price[side][j] = lvl_price[side][j-1];
          lvl_qty[side][j]   = lvl_qty[side][j-1];
          lvl_used[side][j]  = lvl_used[side][j-1];
        end
        lvl_price[side][i] = px;
        lvl_qty[side][i]   = QTY_W'(qty);
        lvl_used[side][i]  = 1'b1;
        placed = 1'b1;
      end
    end
  endfunction

  function automatic out_item_t read_level(input logic side, input logic [LEVEL_W-1:0] lvl);
    out_item_t r;
    r = '0;
    if (int'(lvl) < DEPTH && lvl_used[side][lvl]) begin
      r.level_price    = lvl_price[side][lvl];
      r.level_quantity = lvl_qty[side][lvl];
      r.level_valid    = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        for (int i = 0; i < DEPTH; i++) begin
          lvl_price[s][i] = '0;
          lvl_qty[s][i]   = '0;
          lvl_used[s][i]  = 1'b0;
        end
      end
      level_reads_q.delete();
      pending_cnt = 0;
    end else begin
      // retire the result first: it belongs to an earlier read
      if (out_valid_i && !out_stall_i) begin
        if (level_reads_q.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, got %p", $time, out_item_i);
        end else begin
          want = level_reads_q.pop_front();
          if (out_item_i.level_price !== want.level_price) begin
            mismatches++;
            $display("%0t level_price: expected %0d, got %0d", $time,
                     want.level_price, out_item_i.level_price);
          end
          if (out_item_i.level_quantity !== want.level_quantity) begin
            mismatches++;
            $display("%0t level_quantity: expected %0d, got %0d", $time,
                     want.level_quantity, out_item_i.level_quantity);
          end
          if (out_item_i.level_valid !== want.level_valid) begin
            mismatches++;
            $display("%0t level_valid: expected %0b, got %0b", $time,
                     want.level_valid, out_item_i.level_valid);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (in_item_i.mode == MODE_ADD) begin
          apply_order(in_item_i.side, in_item_i.price, in_item_i.quantity);
        end else begin
          level_reads_q.push_back(read_level(in_item_i.side, in_item_i.level));
        end
      end
      pending_cnt = level_reads_q.size();
    end
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the order book level aggregator: stimulus, receiver stalls and verdict.
module tb_top;
  import obla_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned PRICE_MAX    = (1 << PRICE_W) - 1;
  localparam int unsigned QTY_IN_MAX   = (1 << QTY_IN_W) - 1;
  localparam int unsigned MERGE_ADDS   = 40;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam longint      LIMIT_TIME   = 64'd12_000_000;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  in_item_t           in_item_i   = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  out_item_t          out_item_o;
  int                 fail_count;
  int                 pending;
  bit                 sender_idles   = 1'b1;
  bit                 receiver_idles = 1'b1;
  int                 holds_wanted   = 0;
  logic [PRICE_W-1:0] price_base     = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  order_book_level_aggregator_core #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  obla_level_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_i  (out_item_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    #(LIMIT_TIME);
    $display("[order_book_level_aggregator_core] ERROR");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_wanted > holds_done) begin
        holds_done++;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_stall_i <= receiver_idles && ($urandom_range(99) < 7);
    end
  end

  // call at a falling edge; returns at the falling edge after the item is taken
  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (sender_idles) begin
      while ($urandom_range(99) < 7) gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic in_item_t add_item(input logic side, input int unsigned px,
                                        input int unsigned qty);
    in_item_t it;
    it          = '0;
    it.mode     = MODE_ADD;
    it.side     = side;
    it.price    = PRICE_W'(px);
    it.quantity = QTY_IN_W'(qty);
    it.level    = LEVEL_W'($urandom);
    return it;
  endfunction

  function automatic in_item_t read_item(input logic side, input int unsigned lvl);
    in_item_t it;
    it          = '0;
    it.mode     = MODE_READ;
    it.side     = side;
    it.price    = PRICE_W'($urandom);
    it.quantity = QTY_IN_W'($urandom);
    it.level    = LEVEL_W'(lvl);
    return it;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick;
    it.mode  = ($urandom_range(99) < 60) ? MODE_ADD : MODE_READ;
    it.side  = $urandom_range(1) ? SIDE_SELL : SIDE_BUY;
    it.level = LEVEL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 80) begin
      it.price = price_base + PRICE_W'($urandom_range(47));
    end else if (pick < 86) begin
      it.price = $urandom_range(1) ? '1 : '0;
    end else begin
      it.price = PRICE_W'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 8) begin
      it.quantity = '0;
    end else if (pick < 16) begin
      it.quantity = '1;
    end else begin
      it.quantity = QTY_IN_W'($urandom);
    end
    return it;
  endfunction

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        price_base = PRICE_W'($urandom);
      end
      send_item(rand_item());
    end
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_item(read_item(SIDE_BUY, 0));
    send_item(add_item(SIDE_BUY, 0, 0));
    send_item(add_item(SIDE_BUY, PRICE_MAX, QTY_IN_MAX));
    send_item(add_item(SIDE_BUY, PRICE_MAX, QTY_IN_MAX));
    send_item(add_item(SIDE_SELL, PRICE_MAX, 1));
    send_item(add_item(SIDE_SELL, 0, QTY_IN_MAX));
    send_item(add_item(SIDE_SELL, 0, 0));
    send_item(read_item(SIDE_BUY, 0));
    send_item(read_item(SIDE_BUY, 1));
    send_item(read_item(SIDE_SELL, 0));
    // fill the sell book, push the worst level off, then offer a price worse than all
    for (int p = 10; p < 24; p++) begin
      send_item(add_item(SIDE_SELL, p, p));
    end
    send_item(add_item(SIDE_SELL, 24, 3));
    send_item(add_item(SIDE_SELL, 30, 5));
    send_item(read_item(SIDE_SELL, DEPTH - 1));

    // merge into one level back to back
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    for (int n = 0; n < MERGE_ADDS; n++) begin
      send_item(add_item(SIDE_SELL, 0, QTY_IN_MAX));
    end
    send_item(read_item(SIDE_SELL, 0));

    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    run_random(600);

    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_random(400);

    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    holds_wanted++;
    run_random(200);
    run_random(300);

    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[order_book_level_aggregator_core] OK");
    end else begin
      $display("[order_book_level_aggregator_core] ERROR");
    end
    $finish;
  end

endmodule
